FILE: rtl/vrc_pkg.sv
// vrc_pkg: shared constants of the vector refraction core
// depends on nothing; used by the channel interfaces and every rtl module but vrc_sqrt

package vrc_pkg;

  // index ratio format, unsigned q2.14
  localparam int ETA_W    = 16;
  localparam int ETA_FRAC = 14;

  // eta squared after rounding to eta fraction bits, unsigned, below 16.0
  localparam int E2_W     = 18;

  // stages outside the square root pipeline
  localparam int FRONT_STAGES = 6;
  localparam int BACK_STAGES  = 4;

endpackage

FILE: rtl/vrc_channels.sv
// vrc_in_if / vrc_out_if: valid/ready channels of the vector refraction core
// depends on vrc_pkg for the eta width

interface vrc_in_if #(
  parameter int FRAC_BITS = 16
);
  logic                               valid;
  logic                               ready;
  logic signed [FRAC_BITS+1:0]        in_x;
  logic signed [FRAC_BITS+1:0]        in_y;
  logic signed [FRAC_BITS+1:0]        in_z;
  logic signed [FRAC_BITS+1:0]        norm_x;
  logic signed [FRAC_BITS+1:0]        norm_y;
  logic signed [FRAC_BITS+1:0]        norm_z;
  logic        [vrc_pkg::ETA_W-1:0]   eta;

  modport source (output valid, in_x, in_y, in_z, norm_x, norm_y, norm_z, eta, input ready);
  modport sink   (input valid, in_x, in_y, in_z, norm_x, norm_y, norm_z, eta, output ready);
endinterface

interface vrc_out_if #(
  parameter int FRAC_BITS = 16
);
  logic                               valid;
  logic                               ready;
  logic signed [FRAC_BITS+3:0]        out_x;
  logic signed [FRAC_BITS+3:0]        out_y;
  logic signed [FRAC_BITS+3:0]        out_z;
  logic                               refracts;

  modport source (output valid, out_x, out_y, out_z, refracts, input ready);
  modport sink   (input valid, out_x, out_y, out_z, refracts, output ready);
endinterface

FILE: rtl/vrc_front.sv
// vrc_front: dot product, cosine, discriminant and radicand, six stages
// depends on vrc_pkg; feeds vrc_sqrt with the radicand and the side data

module vrc_front #(
  parameter  int FRAC_BITS = 16,
  localparam int IW  = FRAC_BITS + 2,
  localparam int CW  = FRAC_BITS + 5,
  localparam int RW  = 2 * FRAC_BITS + 12,
  localparam int SW  = 6 * IW + vrc_pkg::ETA_W + CW + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [IW-1:0]         a_x,
  input  logic signed [IW-1:0]         a_y,
  input  logic signed [IW-1:0]         a_z,
  input  logic signed [IW-1:0]         n_x,
  input  logic signed [IW-1:0]         n_y,
  input  logic signed [IW-1:0]         n_z,
  input  logic [vrc_pkg::ETA_W-1:0]    eta,
  output logic                         out_valid,
  output logic [RW-1:0]                rad,
  output logic [SW-1:0]                side
);

  localparam int F    = FRAC_BITS;
  localparam int EF   = vrc_pkg::ETA_FRAC;
  localparam int E2W  = vrc_pkg::E2_W;
  localparam int NST  = vrc_pkg::FRONT_STAGES;
  localparam int PW   = 2 * IW;
  localparam int DW   = 2 * F + 6;
  localparam int CQW  = 2 * CW;
  localparam int OMW  = 2 * F + 11;
  localparam int OFW  = F + 9;
  localparam int EEW  = 2 * vrc_pkg::ETA_W;
  localparam int PPW  = OFW + E2W + 1;
  localparam int XW   = F + 13;
  localparam int DSW  = F + 14;
  localparam int ANW  = 6 * IW + vrc_pkg::ETA_W;

  localparam logic signed [DW-1:0]  HALF_DOT = DW'(1) << (F - 1);
  localparam logic [EEW:0]          HALF_EE  = (EEW + 1)'(1) << (EF - 1);
  localparam logic signed [OMW-1:0] OM_BIAS  = (OMW'(1) << (2 * F)) + (OMW'(1) << (F - 1));
  localparam logic signed [PPW:0]   HALF_P   = (PPW + 1)'(1) << (EF - 1);
  localparam logic signed [DSW-1:0] ONE_F    = DSW'(1) << F;

  logic [NST-1:0]             v_r;
  logic [ANW-1:0]             an_r   [NST];
  logic signed [PW-1:0]       prod_r [3];
  logic [EEW-1:0]             ee_r;
  logic signed [CW-1:0]       c_r    [NST-1];
  logic [E2W-1:0]             e2_r   [3];
  logic signed [CQW-1:0]      cc_r;
  logic signed [OFW-1:0]      omf_r;
  logic signed [PPW-1:0]      p_r;
  logic [RW-1:0]              rad_r;
  logic                       refr_r;

  logic signed [DW-1:0]       dot_h;
  logic signed [CW-1:0]       c_nxt;
  logic [EEW:0]               ee_h;
  logic [E2W-1:0]             e2_nxt;
  logic signed [OMW-1:0]      om_h;
  logic signed [OFW-1:0]      omf_nxt;
  logic signed [PPW:0]        p_h;
  logic signed [XW-1:0]       x_rnd;
  logic signed [DSW-1:0]      disc;
  logic                       refr_nxt;
  logic [RW-1:0]              rad_nxt;

  // stage 2: dot product rounded to the cosine, eta squared rounded
  always_comb begin
    dot_h  = $signed(prod_r[0]) + $signed(prod_r[1]) + $signed(prod_r[2]) + HALF_DOT;
    c_nxt  = $signed(dot_h[F +: CW]);
    ee_h   = {1'b0, ee_r} + HALF_EE;
    e2_nxt = ee_h[EF +: E2W];
  end

  // stage 4: one minus cosine squared, rounded
  always_comb begin
    om_h    = OM_BIAS - {{(OMW - CQW){cc_r[CQW-1]}}, cc_r};
    omf_nxt = $signed(om_h[F +: OFW]);
  end

  // stage 6: discriminant, refraction flag and square root radicand
  always_comb begin
    p_h      = {p_r[PPW-1], p_r} + HALF_P;
    x_rnd    = $signed(p_h[EF +: XW]);
    disc     = ONE_F - {{(DSW - XW){x_rnd[XW-1]}}, x_rnd};
    refr_nxt = !disc[DSW-1] && (disc != '0);
    rad_nxt  = refr_nxt ? {disc[F+11:0], {F{1'b0}}} : '0;
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (en) begin
      an_r[0]   <= {a_x, a_y, a_z, n_x, n_y, n_z, eta};
      for (int i = 1; i < NST; i++) begin
        an_r[i] <= an_r[i-1];
      end
      prod_r[0] <= a_x * n_x;
      prod_r[1] <= a_y * n_y;
      prod_r[2] <= a_z * n_z;
      ee_r      <= eta * eta;
      c_r[0]    <= c_nxt;
      for (int i = 1; i < NST - 1; i++) begin
        c_r[i]  <= c_r[i-1];
      end
      e2_r[0]   <= e2_nxt;
      e2_r[1]   <= e2_r[0];
      e2_r[2]   <= e2_r[1];
      cc_r      <= c_r[0] * c_r[0];
      omf_r     <= omf_nxt;
      p_r       <= $signed({1'b0, e2_r[2]}) * omf_r;
      rad_r     <= rad_nxt;
      refr_r    <= refr_nxt;
    end
  end

  assign out_valid = v_r[NST-1];
  assign rad       = rad_r;
  assign side      = {an_r[NST-1], c_r[NST-2], refr_r};

endmodule

FILE: rtl/vrc_sqrt.sv
// vrc_sqrt: pipelined integer square root, one result bit per stage
// depends on nothing; side data rides along with each radicand

module vrc_sqrt #(
  parameter int QW = 22,
  parameter int SW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*QW-1:0]     rad,
  input  logic [SW-1:0]       side_i,
  output logic                out_valid,
  output logic [QW-1:0]       root,
  output logic [SW-1:0]       side_o
);

  localparam int RMW = QW + 2;

  logic [QW-1:0]    v_r;
  logic [QW-1:0]    q_r    [QW];
  logic [SW-1:0]    side_r [QW];
  logic [2*QW-1:0]  rad_r  [QW-1];
  logic [RMW-1:0]   rem_r  [QW-1];

  // stage v_r valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [2*QW-1:0] rad_in;
    logic [RMW-1:0]  rem_in;
    logic [QW-1:0]   q_in;
    logic [SW-1:0]   sd_in;
    logic [RMW-1:0]  cur;
    logic [RMW-1:0]  trial;
    logic            take;

    if (k == 0) begin : g_first
      assign rad_in = rad;
      assign rem_in = '0;
      assign q_in   = '0;
      assign sd_in  = side_i;
    end else begin : g_next
      assign rad_in = rad_r[k-1];
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign sd_in  = side_r[k-1];
    end

    // bring down the next two radicand bits and try the new root bit
    always_comb begin
      cur   = {rem_in[RMW-3:0], rad_in[2*QW-1 -: 2]};
      trial = {q_in, 2'b01};
      take  = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]    <= {q_in[QW-2:0], take};
        side_r[k] <= sd_in;
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[k] <= {rad_in[2*QW-3:0], 2'b00};
          rem_r[k] <= take ? (cur - trial) : cur;
        end
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign root      = q_r[QW-1];
  assign side_o    = side_r[QW-1];

endmodule

FILE: rtl/vrc_back.sv
// vrc_back: refraction coefficient, scaled vectors, difference and saturation
// depends on vrc_pkg; takes the root and side data from vrc_sqrt

module vrc_back #(
  parameter  int FRAC_BITS = 16,
  localparam int IW  = FRAC_BITS + 2,
  localparam int CW  = FRAC_BITS + 5,
  localparam int QW  = FRAC_BITS + 6,
  localparam int OW  = FRAC_BITS + 4,
  localparam int SW  = 6 * IW + vrc_pkg::ETA_W + CW + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [QW-1:0]         root,
  input  logic [SW-1:0]         side,
  output logic                  out_valid,
  output logic signed [OW-1:0]  res_x,
  output logic signed [OW-1:0]  res_y,
  output logic signed [OW-1:0]  res_z,
  output logic                  res_refr
);

  localparam int F     = FRAC_BITS;
  localparam int EF    = vrc_pkg::ETA_FRAC;
  localparam int EW    = vrc_pkg::ETA_W;
  localparam int NST   = vrc_pkg::BACK_STAGES;
  localparam int ESW   = EW + 1;
  localparam int ECW   = CW + ESW;
  localparam int ECRW  = F + 7;
  localparam int CFW   = F + 8;
  localparam int EAW   = IW + ESW;
  localparam int EARW  = F + 5;
  localparam int CNW   = CFW + IW;
  localparam int CNRW  = F + 9;
  localparam int VW    = F + 10;

  // side data layout, lowest field first
  localparam int C_LO   = 1;
  localparam int ETA_LO = C_LO + CW;
  localparam int N_LO   = ETA_LO + EW;
  localparam int A_LO   = N_LO + 3 * IW;

  localparam logic signed [ECW:0]  HALF_EC = (ECW + 1)'(1) << (EF - 1);
  localparam logic signed [EAW:0]  HALF_EA = (EAW + 1)'(1) << (EF - 1);
  localparam logic signed [CNW:0]  HALF_CN = (CNW + 1)'(1) << (F - 1);
  localparam logic signed [VW-1:0] OUT_MAX = (VW'(1) << (OW - 1)) - VW'(1);
  localparam logic signed [VW-1:0] OUT_MIN = -(VW'(1) << (OW - 1));

  logic [NST-1:0]              v_r;
  // stage 1
  logic signed [ECW-1:0]       ec_r;
  logic [QW-1:0]               s1_r;
  logic [3*IW-1:0]             a1_r;
  logic [3*IW-1:0]             n1_r;
  logic [EW-1:0]               eta1_r;
  logic                        refr1_r;
  // stage 2
  logic signed [CFW-1:0]       coef_r;
  logic signed [EAW-1:0]       ea_r  [3];
  logic [3*IW-1:0]             n2_r;
  logic                        refr2_r;
  // stage 3
  logic signed [CNW-1:0]       cn_r  [3];
  logic signed [EARW-1:0]      ear_r [3];
  logic                        refr3_r;
  // stage 4
  logic signed [OW-1:0]        res_r [3];
  logic                        refr4_r;

  logic signed [ECW:0]         ec_h;
  logic signed [CFW-1:0]       coef_nxt;
  logic signed [ESW-1:0]       eta_s;
  logic signed [EAW:0]         ea_h  [3];
  logic signed [EARW-1:0]      ear_nxt [3];
  logic signed [CNW:0]         cn_h  [3];
  logic signed [CNRW-1:0]      cnr   [3];
  logic signed [VW-1:0]        diff  [3];
  logic signed [OW-1:0]        res_nxt [3];

  assign eta_s = $signed({1'b0, eta1_r});

  // stage 2: coefficient eta*cos + root
  always_comb begin
    ec_h     = {ec_r[ECW-1], ec_r} + HALF_EC;
    coef_nxt = $signed(ec_h[EF +: ECRW]) + $signed({1'b0, s1_r});
  end

  // stage 3: round eta times incident
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ea_h[i]    = {ea_r[i][EAW-1], ea_r[i]} + HALF_EA;
      ear_nxt[i] = $signed(ea_h[i][EF +: EARW]);
    end
  end

  // stage 4: difference, saturation, zero on total internal reflection
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cn_h[i] = {cn_r[i][CNW-1], cn_r[i]} + HALF_CN;
      cnr[i]  = $signed(cn_h[i][F +: CNRW]);
      diff[i] = $signed({{(VW - EARW){ear_r[i][EARW-1]}}, ear_r[i]})
              - $signed({cnr[i][CNRW-1], cnr[i]});
      if (!refr3_r) begin
        res_nxt[i] = '0;
      end else if (diff[i] > OUT_MAX) begin
        res_nxt[i] = OUT_MAX[OW-1:0];
      end else if (diff[i] < OUT_MIN) begin
        res_nxt[i] = OUT_MIN[OW-1:0];
      end else begin
        res_nxt[i] = diff[i][OW-1:0];
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (en) begin
      ec_r    <= $signed({1'b0, side[ETA_LO +: EW]}) * $signed(side[C_LO +: CW]);
      s1_r    <= root;
      a1_r    <= side[A_LO +: 3*IW];
      n1_r    <= side[N_LO +: 3*IW];
      eta1_r  <= side[ETA_LO +: EW];
      refr1_r <= side[0];

      coef_r  <= coef_nxt;
      for (int i = 0; i < 3; i++) begin
        ea_r[i] <= eta_s * $signed(a1_r[(2-i)*IW +: IW]);
      end
      n2_r    <= n1_r;
      refr2_r <= refr1_r;

      for (int i = 0; i < 3; i++) begin
        cn_r[i]  <= coef_r * $signed(n2_r[(2-i)*IW +: IW]);
        ear_r[i] <= ear_nxt[i];
        res_r[i] <= res_nxt[i];
      end
      refr3_r <= refr2_r;
      refr4_r <= refr3_r;
    end
  end

  assign out_valid = v_r[NST-1];
  assign res_x     = res_r[0];
  assign res_y     = res_r[1];
  assign res_z     = res_r[2];
  assign res_refr  = refr4_r;

endmodule

FILE: rtl/vector_refraction_core.sv
// vector_refraction_core: snell refraction of a direction vector, fixed point
// depends on vrc_pkg, vrc_channels, vrc_front, vrc_sqrt and vrc_back
//
//  channel  dir  handshake     words
//  in_ch    in   valid/ready   in_x..in_z, norm_x..norm_z (q1.F), eta (q2.14)
//  out_ch   out  valid/ready   out_x..out_z (q3.F, saturated), refracts
//
// one word per cycle while the skid register is free; the pipeline holds
// six front stages, one square root stage per root bit, four back stages
// a skid register behind the last stage takes one result while out is stalled,
// the whole pipeline then holds until it empties; in_ch.ready drops meanwhile
// synchronous active low reset clears the valid bits, the skid valid flag and the word count

module vector_refraction_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  vrc_in_if.sink   in_ch,
  vrc_out_if.source out_ch
);

  localparam int IW  = FRAC_BITS + 2;
  localparam int CW  = FRAC_BITS + 5;
  localparam int QW  = FRAC_BITS + 6;
  localparam int OW  = FRAC_BITS + 4;
  localparam int SW  = 6 * IW + vrc_pkg::ETA_W + CW + 1;
  localparam int LAT = vrc_pkg::FRONT_STAGES + QW + vrc_pkg::BACK_STAGES;
  localparam int OCW = $clog2(LAT + 2) + 1;

  logic                  en;
  logic                  fr_v;
  logic [2*QW-1:0]       fr_rad;
  logic [SW-1:0]         fr_side;
  logic                  sq_v;
  logic [QW-1:0]         sq_root;
  logic [SW-1:0]         sq_side;
  logic                  bk_v;
  logic signed [OW-1:0]  bk_x;
  logic signed [OW-1:0]  bk_y;
  logic signed [OW-1:0]  bk_z;
  logic                  bk_refr;

  logic                  skid_v_r;
  logic                  skid_v_nxt;
  logic signed [OW-1:0]  skid_x_r;
  logic signed [OW-1:0]  skid_y_r;
  logic signed [OW-1:0]  skid_z_r;
  logic                  skid_refr_r;

  logic [OCW-1:0]        occ_r;
  logic [OCW-1:0]        occ_nxt;
  logic                  in_acc;
  logic                  out_acc;

  // pipeline advances whenever the skid register is free
  assign en          = !skid_v_r;
  assign in_ch.ready = en && rst_n;

  vrc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid && in_ch.ready),
    .a_x       (in_ch.in_x),
    .a_y       (in_ch.in_y),
    .a_z       (in_ch.in_z),
    .n_x       (in_ch.norm_x),
    .n_y       (in_ch.norm_y),
    .n_z       (in_ch.norm_z),
    .eta       (in_ch.eta),
    .out_valid (fr_v),
    .rad       (fr_rad),
    .side      (fr_side)
  );

  vrc_sqrt #(.QW(QW), .SW(SW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_v),
    .rad       (fr_rad),
    .side_i    (fr_side),
    .out_valid (sq_v),
    .root      (sq_root),
    .side_o    (sq_side)
  );

  vrc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .root      (sq_root),
    .side      (sq_side),
    .out_valid (bk_v),
    .res_x     (bk_x),
    .res_y     (bk_y),
    .res_z     (bk_z),
    .res_refr  (bk_refr)
  );

  // skid register: catches the last stage when out stalls
  always_comb begin
    if (skid_v_r) begin
      skid_v_nxt = !out_ch.ready;
    end else begin
      skid_v_nxt = bk_v && !out_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_x_r    <= bk_x;
      skid_y_r    <= bk_y;
      skid_z_r    <= bk_z;
      skid_refr_r <= bk_refr;
    end
  end

  // result word comes from the skid register first
  assign out_ch.valid    = skid_v_r || bk_v;
  assign out_ch.out_x    = skid_v_r ? skid_x_r    : bk_x;
  assign out_ch.out_y    = skid_v_r ? skid_y_r    : bk_y;
  assign out_ch.out_z    = skid_v_r ? skid_z_r    : bk_z;
  assign out_ch.refracts = skid_v_r ? skid_refr_r : bk_refr;

  // words in flight, for the checks below
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) begin
      occ_nxt = occ_r + OCW'(1);
    end else if (!in_acc && out_acc) begin
      occ_nxt = occ_r - OCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // total internal reflection gives a zero vector
  a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.refracts |->
      out_ch.out_x == '0 && out_ch.out_y == '0 && out_ch.out_z == '0)
    else $error("nonzero vector on total internal reflection");

  // a caught result stays until taken
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_ch.ready |=> skid_v_r && $stable(skid_x_r) && $stable(skid_refr_r))
    else $error("skid register lost a stalled word");

  // no more words in flight than pipeline stages plus skid
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCW'(LAT + 1))
    else $error("more words in flight than storage");

  // no result appears without an accepted word behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == '0 |-> !out_ch.valid)
    else $error("result word without an accepted input word");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for vector_refraction_core, a directed table then random rays
// depends on vrc_pkg, vrc_channels and the core; results checked against table values or an in-bench model

module tb;

  localparam int ETA_W        = vrc_pkg::ETA_W;
  localparam int ETA_FRAC     = vrc_pkg::ETA_FRAC;
  localparam int FRAC         = 16;
  localparam int VW           = FRAC + 2;
  localparam int OW           = FRAC + 4;
  localparam int ONE          = 1 << FRAC;
  localparam int ETA_ONE      = 1 << ETA_FRAC;
  localparam int VMAX         = (1 << (VW - 1)) - 1;
  localparam int VMIN         = -(1 << (VW - 1));
  localparam int ETA_MAX      = (1 << ETA_W) - 1;
  localparam int RAND_RAYS    = 750;
  localparam int CALM_FIRST   = 250;
  localparam int CALM_LAST    = 400;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = FRAC + 24;
  localparam int SHOW_LIMIT   = 10;

  typedef struct packed {
    logic signed [VW-1:0] in_x;
    logic signed [VW-1:0] in_y;
    logic signed [VW-1:0] in_z;
    logic signed [VW-1:0] norm_x;
    logic signed [VW-1:0] norm_y;
    logic signed [VW-1:0] norm_z;
    logic [ETA_W-1:0]     eta;
  } ray_word_t;

  typedef struct packed {
    logic signed [OW-1:0] out_x;
    logic signed [OW-1:0] out_y;
    logic signed [OW-1:0] out_z;
    logic                 refracts;
  } bent_ray_t;

  // one directed row; want is only used when known is set
  typedef struct packed {
    ray_word_t ray;
    logic      known;
    bent_ray_t want;
  } ray_row_t;

  logic clk;
  logic rst_n;
  logic calm;
  int   fail_count;

  ray_row_t  ray_rows[$];
  bent_ray_t expected_bends[$];

  vrc_in_if  #(.FRAC_BITS(FRAC)) in_ch ();
  vrc_out_if #(.FRAC_BITS(FRAC)) out_ch ();

  vector_refraction_core #(.FRAC_BITS(FRAC)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // round half up, dropping sh fraction bits
  function automatic longint round_up_half(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  // floor of the square root, v below 2^44
  function automatic longint floor_root(longint v);
    longint r;
    longint t;
    r = 0;
    for (int b = 21; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [OW-1:0] clamp_out(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (OW - 1)) - 1;
    lo = -(longint'(1) << (OW - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OW-1:0];
  endfunction

  // expected bent ray for one incident word
  function automatic bent_ray_t refract_ray(ray_word_t w);
    bent_ray_t b;
    longint a[3];
    longint n[3];
    longint o[3];
    longint e, dot, c, om_f, e2, disc, s, coef;
    a[0] = longint'($signed(w.in_x));
    a[1] = longint'($signed(w.in_y));
    a[2] = longint'($signed(w.in_z));
    n[0] = longint'($signed(w.norm_x));
    n[1] = longint'($signed(w.norm_y));
    n[2] = longint'($signed(w.norm_z));
    e    = longint'(w.eta);
    dot  = a[0] * n[0] + a[1] * n[1] + a[2] * n[2];
    c    = round_up_half(dot, FRAC);
    om_f = round_up_half((longint'(1) << (2 * FRAC)) - c * c, FRAC);
    e2   = round_up_half(e * e, ETA_FRAC);
    disc = (longint'(1) << FRAC) - round_up_half(e2 * om_f, ETA_FRAC);
    b    = '0;
    // grazing and total internal reflection both give a zero vector
    if (disc <= 0) return b;
    s    = floor_root(disc << FRAC);
    coef = round_up_half(e * c, ETA_FRAC) + s;
    for (int i = 0; i < 3; i++)
      o[i] = round_up_half(e * a[i], ETA_FRAC) - round_up_half(coef * n[i], FRAC);
    b.out_x    = clamp_out(o[0]);
    b.out_y    = clamp_out(o[1]);
    b.out_z    = clamp_out(o[2]);
    b.refracts = 1'b1;
    return b;
  endfunction

  function automatic logic signed [VW-1:0] to_fixed(real r);
    int v;
    v = $rtoi(r * ONE);
    if (v > VMAX) v = VMAX;
    if (v < VMIN) v = VMIN;
    return v[VW-1:0];
  endfunction

  // mostly physical rays: unit vectors facing the surface, some stretched;
  // the rest raw bits
  function automatic ray_word_t random_ray();
    ray_word_t w;
    logic [127:0] raw;
    real d[3];
    real m[3];
    real ld, lm, dt, sc;
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      w   = raw[$bits(ray_word_t)-1:0];
      return w;
    end
    for (int i = 0; i < 3; i++) begin
      d[i] = (real'($urandom_range(2000)) - 1000.0) / 1000.0;
      m[i] = (real'($urandom_range(2000)) - 1000.0) / 1000.0;
    end
    ld = $sqrt(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]);
    lm = $sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    if (ld < 0.05) begin
      d[0] = 0.0; d[1] = 0.0; d[2] = -1.0; ld = 1.0;
    end
    if (lm < 0.05) begin
      m[0] = 0.0; m[1] = 0.0; m[2] = 1.0; lm = 1.0;
    end
    dt = 0.0;
    for (int i = 0; i < 3; i++) begin
      d[i] = d[i] / ld;
      m[i] = m[i] / lm;
      dt   = dt + d[i] * m[i];
    end
    sc = 1.0;
    if ($urandom_range(9) == 0) sc = 1.0 + real'($urandom_range(999)) / 1000.0;
    // incident ray points against the normal most of the time
    if (dt > 0.0 && $urandom_range(9) != 0) sc = -sc;
    w.in_x   = to_fixed(d[0] * sc);
    w.in_y   = to_fixed(d[1] * sc);
    w.in_z   = to_fixed(d[2] * sc);
    w.norm_x = to_fixed(m[0]);
    w.norm_y = to_fixed(m[1]);
    w.norm_z = to_fixed(m[2]);
    pick = $urandom_range(99);
    if (pick < 60)      w.eta = ETA_W'($urandom_range(2 * ETA_ONE, ETA_ONE / 2));
    else if (pick < 80) w.eta = ETA_W'($urandom_range(ETA_MAX));
    else if (pick < 90) w.eta = ETA_W'(ETA_ONE + $urandom_range(64) - 32);
    else                w.eta = '0;
    return w;
  endfunction

  task automatic add_row(input int ax, ay, az, nx, ny, nz, e,
                         input logic known, input int ox, oy, oz, input logic rf);
    ray_row_t r;
    r.ray           = '{in_x: VW'(ax), in_y: VW'(ay), in_z: VW'(az), norm_x: VW'(nx),
                        norm_y: VW'(ny), norm_z: VW'(nz), eta: ETA_W'(e)};
    r.known         = known;
    r.want.out_x    = OW'(ox);
    r.want.out_y    = OW'(oy);
    r.want.out_z    = OW'(oz);
    r.want.refracts = rf;
    ray_rows.push_back(r);
  endtask

  // present one word, at times after a random gap outside the calm stretch; returns at the accepting edge
  task automatic send_ray(input ray_word_t w, input bent_ray_t want);
    if (!calm && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_ch.valid  <= 1'b1;
    in_ch.in_x   <= w.in_x;
    in_ch.in_y   <= w.in_y;
    in_ch.in_z   <= w.in_z;
    in_ch.norm_x <= w.norm_x;
    in_ch.norm_y <= w.norm_y;
    in_ch.norm_z <= w.norm_z;
    in_ch.eta    <= w.eta;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_bends.push_back(want);
  endtask

  // result side stalls at random except in the calm stretch
  initial out_ch.ready = 1'b0;
  always @(posedge clk) out_ch.ready <= calm || ($urandom_range(99) >= 20);

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : check_bends
    bent_ray_t got;
    bent_ray_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.refracts};
      if (expected_bends.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("tb: unexpected result word x=%0d y=%0d z=%0d refracts=%0b",
                   got.out_x, got.out_y, got.out_z, got.refracts);
      end else begin
        want = expected_bends.pop_front();
        if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
            got.out_z !== want.out_z || got.refracts !== want.refracts) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("tb: mismatch exp x=%0d y=%0d z=%0d r=%0b got x=%0d y=%0d z=%0d r=%0b",
                     want.out_x, want.out_y, want.out_z, want.refracts,
                     got.out_x, got.out_y, got.out_z, got.refracts);
        end
      end
    end
  end

  // watchdog: too long without any word moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    ray_word_t w;
    in_ch.valid  = 1'b0;
    in_ch.in_x   = '0;
    in_ch.in_y   = '0;
    in_ch.in_z   = '0;
    in_ch.norm_x = '0;
    in_ch.norm_y = '0;
    in_ch.norm_z = '0;
    in_ch.eta    = '0;
    rst_n        = 1'b0;
    calm         = 1'b0;
    fail_count   = 0;

    // directed rays: in x,y,z, normal x,y,z, eta, known, out x,y,z, refracts
    // all zero with eta zero: disc is one, nothing to subtract
    add_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
    // eta zero gives minus the normal
    add_row(12345, -777, 4000, 0, 0, ONE, 0, 1, 0, 0, -ONE, 1);
    add_row(VMIN, VMIN, VMIN, VMAX, VMAX, VMAX, 0, 1, -VMAX, -VMAX, -VMAX, 1);
    add_row(VMAX, VMAX, VMAX, VMIN, VMIN, VMIN, 0, 1, -VMIN, -VMIN, -VMIN, 1);
    // head-on ray with matched media passes straight through
    add_row(0, 0, -ONE, 0, 0, ONE, ETA_ONE, 1, 0, 0, -ONE, 1);
    // grazing incidence with eta one: disc exactly zero
    add_row(ONE, 0, 0, 0, 0, ONE, ETA_ONE, 1, 0, 0, 0, 0);
    // total internal reflection at the largest eta
    add_row(ONE, 0, 0, 0, ONE, 0, ETA_MAX, 1, 0, 0, 0, 0);
    // extremes and saturation, left to the model
    add_row(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, ETA_MAX, 0, 0, 0, 0, 0);
    add_row(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, ETA_MAX, 0, 0, 0, 0, 0);
    add_row(VMAX, VMAX, VMAX, VMIN, VMIN, VMIN, ETA_ONE, 0, 0, 0, 0, 0);
    add_row(VMIN, 0, 0, 0, 0, -ONE, ETA_MAX, 0, 0, 0, 0, 0);
    add_row(VMAX, 0, VMIN, 0, VMAX, 0, 3 * ETA_ONE, 0, 0, 0, 0, 0);
    // oblique entry into glass, and just under grazing
    add_row(46341, 0, -46341, 0, 0, ONE, 10923, 0, 0, 0, 0, 0);
    add_row(ONE, 0, 0, 0, 0, ONE, ETA_ONE - 1, 0, 0, 0, 0, 0);
    // normal far from unit length, then a unit normal with eta 1.5
    add_row(-ONE, -ONE, -ONE, VMAX, VMAX, VMAX, 24576, 0, 0, 0, 0, 0);
    add_row(-20000, 30000, -50000, 0, -ONE, 0, ETA_ONE + ETA_ONE / 2, 0, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (ray_rows[i])
      send_ray(ray_rows[i].ray,
               ray_rows[i].known ? ray_rows[i].want : refract_ray(ray_rows[i].ray));

    // random rays, with a stretch where neither side idles
    for (int k = 0; k < RAND_RAYS; k++) begin
      calm = (k >= CALM_FIRST && k < CALM_LAST);
      w = random_ray();
      send_ray(w, refract_ray(w));
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (expected_bends.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
rtl/vrc_pkg.sv
rtl/vrc_channels.sv
rtl/vrc_front.sv
rtl/vrc_sqrt.sv
rtl/vrc_back.sv
rtl/vector_refraction_core.sv
dv/tb.sv
